/* rtl/zmpc_pkg.sv */
// ============================================================================
// zmpc_pkg
// Shared types, constants and Q16.16 helpers for the ZMP preview controller.
// ============================================================================
package zmpc_pkg;

    // window and gain store geometry
    localparam int PREVIEW_LEN = 256;
    localparam int TAP_BASE    = 16;
    localparam int GAIN_WORDS  = TAP_BASE + 4 * PREVIEW_LEN;
    localparam int GAIN_AW     = $clog2(GAIN_WORDS);
    localparam int WIN_AW      = $clog2(PREVIEW_LEN);
    localparam int FILL_W      = $clog2(PREVIEW_LEN + 1);
    localparam int WIN_DW      = 64;

    // configuration port
    localparam int CFG_IW = 2;
    localparam int CFG_DW = 21;
    localparam logic [CFG_IW-1:0] REG_DT   = 2'd0;
    localparam logic [CFG_IW-1:0] REG_HDT2 = 2'd1;
    localparam logic [CFG_IW-1:0] REG_SDT3 = 2'd2;
    localparam logic [CFG_IW-1:0] REG_HOG  = 2'd3;

    // opcodes
    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_SAMPLE  = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // accumulator file indexes
    localparam int ACC_NUM = 14;
    localparam logic [3:0] ACC_NS0  = 4'd0;
    localparam logic [3:0] ACC_ZMP0 = 4'd6;
    localparam logic [3:0] ACC_T1_0 = 4'd8;
    localparam logic [3:0] ACC_T2_0 = 4'd10;
    localparam logic [3:0] ACC_T3_0 = 4'd12;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [10:0]        coef_index;
        logic signed [31:0] coef_value;
        logic signed [31:0] ref_x;
        logic signed [31:0] ref_y;
    } zmpc_in_t;

    typedef struct packed {
        logic signed [31:0] com_x;
        logic signed [31:0] com_y;
        logic signed [31:0] model_zmp_x;
        logic signed [31:0] model_zmp_y;
        logic signed [31:0] jerk_x;
        logic signed [31:0] jerk_y;
    } zmpc_out_t;

    typedef enum logic [2:0] {
        PH_IDLE, PH_TAP, PH_PLANT, PH_ZMP, PH_ERR, PH_GAIN, PH_FINAL, PH_DRAIN
    } phase_t;

    typedef enum logic [2:0] {
        A_GAIN, A_DT, A_HDT2, A_SDT3, A_HOG
    } a_src_t;

    typedef enum logic [4:0] {
        B_V0, B_V1, B_A0, B_A1, B_U0, B_U1, B_NA0, B_NA1, B_ERR0, B_ERR1,
        B_DX0, B_DX1, B_DX2, B_DX3, B_DX4, B_DX5, B_DDX, B_DDY
    } b_src_t;

    // one multiply-accumulate operation
    typedef struct packed {
        logic       valid;
        a_src_t     a_src;
        b_src_t     b_src;
        logic [3:0] dest;
        logic       neg;
    } mac_op_t;

    localparam mac_op_t MAC_NOP = '{valid: 1'b0, a_src: A_GAIN, b_src: B_V0,
                                    dest: 4'd0, neg: 1'b0};

    // saturate a 33-bit sum to 32 bits
    function automatic logic signed [31:0] sat33(input logic signed [32:0] s);
        logic signed [31:0] r;
        if (s[32] != s[31])
            r = s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        else
            r = s[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return sat33({a[31], a} + {b[31], b});
    endfunction

    function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return sat33({a[31], a} - {b[31], b});
    endfunction

    // floor shift by 16 of a full product, saturated to 32 bits
    function automatic logic signed [31:0] qscale(input logic signed [63:0] p);
        logic signed [31:0] r;
        if (p[63:47] != {17{p[63]}})
            r = p[63] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        else
            r = p[47:16];
        return r;
    endfunction

    // circular window address
    function automatic logic [WIN_AW-1:0] win_wrap(input logic [WIN_AW-1:0] a,
                                                   input logic [WIN_AW-1:0] b);
        logic [WIN_AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (WIN_AW+1)'(PREVIEW_LEN))
            s = s - (WIN_AW+1)'(PREVIEW_LEN);
        return s[WIN_AW-1:0];
    endfunction

    // plant advance: six products per axis, axis x first
    function automatic mac_op_t plant_op(input logic [3:0] step);
        mac_op_t op;
        logic    ax;
        op = MAC_NOP;
        ax = (step >= 4'd6);
        op.valid = (step < 4'd12);
        unique case (ax ? step - 4'd6 : step)
            4'd0:    begin op.a_src = A_DT;   op.b_src = ax ? B_V1 : B_V0; op.dest = 4'(ax);     end
            4'd1:    begin op.a_src = A_HDT2; op.b_src = ax ? B_A1 : B_A0; op.dest = 4'(ax);     end
            4'd2:    begin op.a_src = A_SDT3; op.b_src = ax ? B_U1 : B_U0; op.dest = 4'(ax);     end
            4'd3:    begin op.a_src = A_DT;   op.b_src = ax ? B_A1 : B_A0; op.dest = 4'(ax) + 4'd2; end
            4'd4:    begin op.a_src = A_HDT2; op.b_src = ax ? B_U1 : B_U0; op.dest = 4'(ax) + 4'd2; end
            4'd5:    begin op.a_src = A_DT;   op.b_src = ax ? B_U1 : B_U0; op.dest = 4'(ax) + 4'd4; end
            default: op = MAC_NOP;
        endcase
        return op;
    endfunction

    // feedback gains: G1 words 0-3 then G2 words 4-15, row-major
    function automatic mac_op_t gain_op(input logic [3:0] idx);
        mac_op_t    op;
        logic [3:0] c;
        op = MAC_NOP;
        op.valid = 1'b1;
        op.a_src = A_GAIN;
        if (idx < 4'd4) begin
            op.dest  = ACC_T1_0 + 4'(idx[1]);
            op.b_src = b_src_t'(5'(B_ERR0) + 5'(idx[0]));
        end else if (idx < 4'd10) begin
            c        = idx - 4'd4;
            op.dest  = ACC_T2_0;
            op.b_src = b_src_t'(5'(B_DX0) + 5'(c));
        end else begin
            c        = idx - 4'd10;
            op.dest  = ACC_T2_0 + 4'd1;
            op.b_src = b_src_t'(5'(B_DX0) + 5'(c));
        end
        return op;
    endfunction

endpackage

/* rtl/zmpc_ram.sv */
// ============================================================================
// zmpc_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ============================================================================
module zmpc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/zmp_preview_com_controller.sv */
// ============================================================================
// zmp_preview_com_controller
// Two-axis cart-table preview controller in Q16.16 with a shared multiplier.
// ============================================================================
//
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    in_data  (zmpc_in_t)
// out       output     out_valid / out_ready  out_data (zmpc_out_t)
// cfg       input      cfg_we                 cfg_index, cfg_data
//
// loads, restarts and samples that leave the window short keep in_ready high.
// a sample that fills the window drops in_ready while the preview walk reads
// one window row and four gain words per tap through the single read port of
// the gain RAM, then the plant, zmp and gain steps run on the same multiplier.
// reset clears the plant, jerk, window fill and registers; the gain RAM and
// window RAM are not cleared. in_ready is low while a sample is being worked
// on; the result is held in an output register and a new transaction is taken
// while it waits, with the next result held back until it has gone.
//
module zmp_preview_com_controller
    import zmpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  zmpc_in_t          in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output zmpc_out_t         out_data,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data
);

    // configuration
    logic [16:0] dt_reg, hdt2_reg, sdt3_reg;
    logic [20:0] hog_reg;

    // plant, jerk and work registers
    logic signed [31:0] plant_reg [6];
    logic signed [31:0] jerk_reg  [2];
    logic signed [31:0] acc_reg   [ACC_NUM];
    logic signed [31:0] err_reg   [2];
    logic signed [31:0] dx_reg    [6];
    logic signed [31:0] w0_reg    [2];
    logic signed [31:0] prev_reg  [2];
    logic signed [31:0] dd_reg    [2];
    logic signed [63:0] prod_reg;

    // sequencing
    phase_t             phase_reg, phase_next;
    phase_t             drain_to_reg, drain_to_next;
    logic               drain_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic [WIN_AW-1:0]  head_reg;
    logic [WIN_AW-1:0]  j_reg;
    logic [2:0]         w_reg;
    logic [3:0]         step_reg;
    mac_op_t            op_issue, op_m_reg, op_a_reg;
    logic               out_valid_reg;
    zmpc_out_t          out_data_reg;

    // memories
    logic               gain_we;
    logic [GAIN_AW-1:0] gain_waddr, gain_raddr;
    logic [31:0]        gain_rdata;
    logic               win_we;
    logic [WIN_AW-1:0]  win_waddr, win_raddr;
    logic [WIN_DW-1:0]  win_rdata;

    logic               accept, start;
    logic signed [31:0] a_val, b_val, q_val, acc_sel;
    logic signed [31:0] win_x, win_y;
    logic signed [31:0] u_new [2];
    logic [1:0]         tap_k;

    assign accept    = in_valid && in_ready;
    assign start     = accept && (in_data.opcode == OP_SAMPLE)
                       && (fill_reg == FILL_W'(PREVIEW_LEN - 1));
    assign in_ready  = (phase_reg == PH_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign win_x     = win_rdata[63:32];
    assign win_y     = win_rdata[31:0];
    assign tap_k     = 2'(w_reg - 3'd1);

    // gain store and window store
    assign gain_we    = accept && (in_data.opcode == OP_LOAD)
                        && (32'(in_data.coef_index) < GAIN_WORDS);
    assign gain_waddr = GAIN_AW'(32'(in_data.coef_index));
    assign win_we     = accept && (in_data.opcode == OP_SAMPLE);
    assign win_waddr  = win_wrap(head_reg, fill_reg[WIN_AW-1:0]);

    zmpc_ram #(.WIDTH(32), .DEPTH(GAIN_WORDS)) u_gain_ram (
        .clk   (clk),
        .we    (gain_we),
        .waddr (gain_waddr),
        .wdata (in_data.coef_value),
        .raddr (gain_raddr),
        .rdata (gain_rdata)
    );

    zmpc_ram #(.WIDTH(WIN_DW), .DEPTH(PREVIEW_LEN)) u_win_ram (
        .clk   (clk),
        .we    (win_we),
        .waddr (win_waddr),
        .wdata ({in_data.ref_x, in_data.ref_y}),
        .raddr (win_raddr),
        .rdata (win_rdata)
    );

    // next phase
    always_comb
    begin
        phase_next    = phase_reg;
        drain_to_next = drain_to_reg;
        unique case (phase_reg)
            PH_IDLE:
                if (start)
                    phase_next = PH_TAP;
            PH_TAP:
                if (w_reg == 3'd4 && j_reg == WIN_AW'(PREVIEW_LEN - 1))
                    phase_next = PH_PLANT;
            PH_PLANT:
                if (step_reg == 4'd11)
                begin
                    phase_next    = PH_DRAIN;
                    drain_to_next = PH_ZMP;
                end
            PH_ZMP:
                if (step_reg == 4'd1)
                begin
                    phase_next    = PH_DRAIN;
                    drain_to_next = PH_ERR;
                end
            PH_ERR:
                phase_next = PH_GAIN;
            PH_GAIN:
                if (step_reg == 4'd15)
                begin
                    phase_next    = PH_DRAIN;
                    drain_to_next = PH_FINAL;
                end
            PH_DRAIN:
                if (drain_reg)
                    phase_next = drain_to_reg;
            PH_FINAL:
                if (!out_valid_reg)
                    phase_next = PH_IDLE;
            default:
                phase_next = PH_IDLE;
        endcase
    end

    // operation issue and read addresses
    always_comb
    begin
        op_issue   = MAC_NOP;
        gain_raddr = '0;
        win_raddr  = win_wrap(head_reg, j_reg);
        unique case (phase_reg)
            PH_TAP:
            begin
                gain_raddr = GAIN_AW'(TAP_BASE) + GAIN_AW'({j_reg, tap_k});
                if (w_reg != 3'd0 && j_reg != '0)
                begin
                    op_issue.valid = 1'b1;
                    op_issue.a_src = A_GAIN;
                    op_issue.b_src = tap_k[0] ? B_DDY : B_DDX;
                    op_issue.dest  = ACC_T3_0 + 4'(tap_k[1]);
                end
            end
            PH_PLANT:
                op_issue = plant_op(step_reg);
            PH_ZMP:
            begin
                op_issue.valid = 1'b1;
                op_issue.a_src = A_HOG;
                op_issue.b_src = step_reg[0] ? B_NA1 : B_NA0;
                op_issue.dest  = ACC_ZMP0 + 4'(step_reg[0]);
                op_issue.neg   = 1'b1;
            end
            PH_GAIN:
            begin
                op_issue   = gain_op(step_reg);
                gain_raddr = GAIN_AW'(step_reg);
            end
            default:
                op_issue = MAC_NOP;
        endcase
    end

    // multiplier operands
    always_comb
    begin
        unique case (op_m_reg.a_src)
            A_GAIN:  a_val = gain_rdata;
            A_DT:    a_val = $signed({15'd0, dt_reg});
            A_HDT2:  a_val = $signed({15'd0, hdt2_reg});
            A_SDT3:  a_val = $signed({15'd0, sdt3_reg});
            A_HOG:   a_val = $signed({11'd0, hog_reg});
            default: a_val = '0;
        endcase
        unique case (op_m_reg.b_src)
            B_V0:    b_val = plant_reg[2];
            B_V1:    b_val = plant_reg[3];
            B_A0:    b_val = plant_reg[4];
            B_A1:    b_val = plant_reg[5];
            B_U0:    b_val = jerk_reg[0];
            B_U1:    b_val = jerk_reg[1];
            B_NA0:   b_val = acc_reg[4];
            B_NA1:   b_val = acc_reg[5];
            B_ERR0:  b_val = err_reg[0];
            B_ERR1:  b_val = err_reg[1];
            B_DX0:   b_val = dx_reg[0];
            B_DX1:   b_val = dx_reg[1];
            B_DX2:   b_val = dx_reg[2];
            B_DX3:   b_val = dx_reg[3];
            B_DX4:   b_val = dx_reg[4];
            B_DX5:   b_val = dx_reg[5];
            B_DDX:   b_val = dd_reg[0];
            B_DDY:   b_val = dd_reg[1];
            default: b_val = '0;
        endcase
    end

    // accumulate stage operands
    assign q_val   = qscale(prod_reg);
    assign acc_sel = acc_reg[op_a_reg.dest];

    // jerk update from the three gain sums
    always_comb
    begin
        for (int r = 0; r < 2; r++)
        begin
            u_new[r] = qsub(qsub(qsub(jerk_reg[r], acc_reg[ACC_T1_0 + 4'(r)]),
                                 acc_reg[ACC_T2_0 + 4'(r)]),
                            acc_reg[ACC_T3_0 + 4'(r)]);
        end
    end

    // control state and registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dt_reg        <= 17'd655;
            hdt2_reg      <= 17'd3;
            sdt3_reg      <= 17'd0;
            hog_reg       <= 21'd5679;
            phase_reg     <= PH_IDLE;
            drain_to_reg  <= PH_IDLE;
            drain_reg     <= 1'b0;
            fill_reg      <= '0;
            head_reg      <= '0;
            j_reg         <= '0;
            w_reg         <= '0;
            step_reg      <= '0;
            op_m_reg      <= MAC_NOP;
            op_a_reg      <= MAC_NOP;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < 6; k++)
                plant_reg[k] <= '0;
            jerk_reg[0]   <= '0;
            jerk_reg[1]   <= '0;
        end
        else
        begin
            // configuration writes
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_DT:   dt_reg   <= cfg_data[16:0];
                    REG_HDT2: hdt2_reg <= cfg_data[16:0];
                    REG_SDT3: sdt3_reg <= cfg_data[16:0];
                    REG_HOG:  hog_reg  <= cfg_data;
                    default:  dt_reg   <= dt_reg;
                endcase
            end

            phase_reg    <= phase_next;
            drain_to_reg <= drain_to_next;
            op_m_reg     <= op_issue;
            op_a_reg     <= op_m_reg;
            drain_reg    <= (phase_reg == PH_DRAIN) && !drain_reg;

            // step counter for the short phases
            if (phase_next != phase_reg)
                step_reg <= '0;
            else
                step_reg <= step_reg + 4'd1;

            // input transactions
            if (accept)
            begin
                if (in_data.opcode == OP_RESTART)
                begin
                    fill_reg <= '0;
                    for (int k = 0; k < 6; k++)
                        plant_reg[k] <= '0;
                    jerk_reg[0] <= '0;
                    jerk_reg[1] <= '0;
                end
                else if (in_data.opcode == OP_SAMPLE)
                begin
                    fill_reg <= fill_reg + FILL_W'(1);
                end
                j_reg <= '0;
                w_reg <= '0;
            end

            // preview walk counters
            if (phase_reg == PH_TAP)
            begin
                if (w_reg == 3'd4)
                begin
                    w_reg <= '0;
                    j_reg <= j_reg + WIN_AW'(1);
                end
                else
                begin
                    w_reg <= w_reg + 3'd1;
                end
            end

            // commit and present the result
            if (phase_reg == PH_FINAL && !out_valid_reg)
            begin
                for (int k = 0; k < 6; k++)
                    plant_reg[k] <= acc_reg[k];
                jerk_reg[0]   <= u_new[0];
                jerk_reg[1]   <= u_new[1];
                fill_reg      <= FILL_W'(PREVIEW_LEN - 1);
                head_reg      <= win_wrap(head_reg, WIN_AW'(1));
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= a_val * b_val;

        // accumulator file
        if (start)
        begin
            for (int k = 0; k < 6; k++)
                acc_reg[k] <= plant_reg[k];
            for (int k = 8; k < ACC_NUM; k++)
                acc_reg[k] <= '0;
        end
        else if (phase_reg == PH_ZMP && step_reg == 4'd0)
        begin
            acc_reg[ACC_ZMP0]        <= acc_reg[0];
            acc_reg[ACC_ZMP0 + 4'd1] <= acc_reg[1];
        end
        else if (op_a_reg.valid)
        begin
            acc_reg[op_a_reg.dest] <= op_a_reg.neg ? qsub(acc_sel, q_val)
                                                   : qadd(acc_sel, q_val);
        end

        // window differences
        if (phase_reg == PH_TAP && w_reg == 3'd1)
        begin
            prev_reg[0] <= win_x;
            prev_reg[1] <= win_y;
            if (j_reg == '0)
            begin
                w0_reg[0] <= win_x;
                w0_reg[1] <= win_y;
            end
            else
            begin
                dd_reg[0] <= qsub(win_x, prev_reg[0]);
                dd_reg[1] <= qsub(win_y, prev_reg[1]);
            end
        end

        // tracking error and state change
        if (phase_reg == PH_ERR)
        begin
            err_reg[0] <= qsub(acc_reg[ACC_ZMP0], w0_reg[0]);
            err_reg[1] <= qsub(acc_reg[ACC_ZMP0 + 4'd1], w0_reg[1]);
            for (int k = 0; k < 6; k++)
                dx_reg[k] <= qsub(acc_reg[k], plant_reg[k]);
        end

        // output payload
        if (phase_reg == PH_FINAL && !out_valid_reg)
        begin
            out_data_reg.com_x       <= acc_reg[0];
            out_data_reg.com_y       <= acc_reg[1];
            out_data_reg.model_zmp_x <= acc_reg[ACC_ZMP0];
            out_data_reg.model_zmp_y <= acc_reg[ACC_ZMP0 + 4'd1];
            out_data_reg.jerk_x      <= u_new[0];
            out_data_reg.jerk_y      <= u_new[1];
        end
    end

    // the multiply pipeline is empty whenever results are committed
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_FINAL) |-> (!op_m_reg.valid && !op_a_reg.valid))
        else $error("mac pipeline busy at commit");

    // a new result leaves the window one short of full
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg)) |-> (fill_reg == FILL_W'(PREVIEW_LEN - 1)))
        else $error("window fill wrong after result");

    // fill never passes the window length
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(PREVIEW_LEN))
        else $error("window fill overflow");

endmodule

/* tb/zmp_preview_com_controller_test.sv */
// ============================================================================
// zmp_preview_com_controller_test
// Self-checking bench for the preview controller: loads the gain store, fills
// the reference window and streams samples through several register settings.
// Every accepted transaction is predicted in Q16.16 and each result is
// compared field by field against the oldest pending prediction.
// ============================================================================
`timescale 1ns / 1ps

module zmp_preview_com_controller_test;
    import zmpc_pkg::*;

    localparam int IDLE_WAIT   = 5 * PREVIEW_LEN + 100;
    localparam int STALL_LIMIT = 20000;
    localparam int PHASE_ITEMS = 16;

    // opcode with no meaning, ignored by the block
    localparam logic [1:0] OP_SPARE = 2'd3;

    // predicts the controller and holds the results still to arrive
    class com_scoreboard;
        int        dt_q;
        int        hdt2_q;
        int        sdt3_q;
        int        hog_q;
        int        plant[6];
        int        plant_old[6];
        int        jerk[2];
        int        win_x[PREVIEW_LEN];
        int        win_y[PREVIEW_LEN];
        int        fill;
        int        gains[GAIN_WORDS];
        zmpc_out_t pending[$];
        int        errors;

        function new();
            dt_q   = 655;
            hdt2_q = 3;
            sdt3_q = 0;
            hog_q  = 5679;
            errors = 0;
            clear_run();
        endfunction

        function void clear_run();
            foreach (plant[k])
            begin
                plant[k]     = 0;
                plant_old[k] = 0;
            end
            jerk[0] = 0;
            jerk[1] = 0;
            fill    = 0;
        endfunction

        function int sat(longint v);
            if (v > 64'sd2147483647)
                return 32'sh7fff_ffff;
            if (v < -64'sd2147483648)
                return 32'sh8000_0000;
            return int'(v);
        endfunction

        function int add(int a, int b);
            return sat(longint'(a) + longint'(b));
        endfunction

        function int sub(int a, int b);
            return sat(longint'(a) - longint'(b));
        endfunction

        // floor of the full product over 2^16
        function int mul(int a, int b);
            longint p;
            p = longint'(a) * longint'(b);
            return sat(p >>> 16);
        endfunction

        function void write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
            case (idx)
                REG_DT:   dt_q   = int'(val[16:0]);
                REG_HDT2: hdt2_q = int'(val[16:0]);
                REG_SDT3: sdt3_q = int'(val[16:0]);
                REG_HOG:  hog_q  = int'(val[20:0]);
                default: ;
            endcase
        endfunction

        // advance the prediction for one accepted input transaction
        function void note_input(zmpc_in_t d);
            int        ns[6];
            int        dx[6];
            int        zmp[2];
            int        err[2];
            int        u;
            int        t;
            int        base;
            zmpc_out_t r;
            if (d.opcode == OP_LOAD)
            begin
                if (d.coef_index < GAIN_WORDS)
                    gains[d.coef_index] = d.coef_value;
                return;
            end
            if (d.opcode == OP_RESTART)
            begin
                clear_run();
                return;
            end
            if (d.opcode != OP_SAMPLE)
                return;
            if (fill >= PREVIEW_LEN)
                fill = PREVIEW_LEN - 1;
            win_x[fill] = d.ref_x;
            win_y[fill] = d.ref_y;
            fill++;
            if (fill < PREVIEW_LEN)
                return;
            // plant advance and model zmp per axis
            for (int a = 0; a < 2; a++)
            begin
                ns[a] = add(add(add(plant[a], mul(dt_q, plant[2+a])),
                                mul(hdt2_q, plant[4+a])), mul(sdt3_q, jerk[a]));
                ns[2+a] = add(add(plant[2+a], mul(dt_q, plant[4+a])),
                              mul(hdt2_q, jerk[a]));
                ns[4+a] = add(plant[4+a], mul(dt_q, jerk[a]));
                zmp[a]  = sub(ns[a], mul(hog_q, ns[4+a]));
            end
            err[0] = sub(zmp[0], win_x[0]);
            err[1] = sub(zmp[1], win_y[0]);
            for (int k = 0; k < 6; k++)
                dx[k] = sub(ns[k], plant_old[k]);
            // jerk update: tracking error, state change, preview sum
            for (int r0 = 0; r0 < 2; r0++)
            begin
                u = jerk[r0];
                t = 0;
                for (int c = 0; c < 2; c++)
                    t = add(t, mul(gains[r0*2+c], err[c]));
                u = sub(u, t);
                t = 0;
                for (int c = 0; c < 6; c++)
                    t = add(t, mul(gains[4+r0*6+c], dx[c]));
                u = sub(u, t);
                t = 0;
                for (int j = 1; j < PREVIEW_LEN; j++)
                begin
                    base = TAP_BASE + 4*j + 2*r0;
                    t = add(t, mul(gains[base], sub(win_x[j], win_x[j-1])));
                    t = add(t, mul(gains[base+1], sub(win_y[j], win_y[j-1])));
                end
                jerk[r0] = sub(u, t);
            end
            plant     = ns;
            plant_old = ns;
            for (int j = 0; j < PREVIEW_LEN - 1; j++)
            begin
                win_x[j] = win_x[j+1];
                win_y[j] = win_y[j+1];
            end
            fill = PREVIEW_LEN - 1;
            r.com_x       = ns[0];
            r.com_y       = ns[1];
            r.model_zmp_x = zmp[0];
            r.model_zmp_y = zmp[1];
            r.jerk_x      = jerk[0];
            r.jerk_y      = jerk[1];
            pending = {pending, r};
        endfunction

        function void compare(string name, int exp_v, int act_v);
            if (exp_v != act_v)
            begin
                $error("%s expected %0d got %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(zmpc_out_t got);
            zmpc_out_t e;
            if (pending.size() == 0)
            begin
                $error("result with no prediction waiting");
                errors++;
                return;
            end
            e = pending.pop_front();
            compare("com_x", e.com_x, got.com_x);
            compare("com_y", e.com_y, got.com_y);
            compare("model_zmp_x", e.model_zmp_x, got.model_zmp_x);
            compare("model_zmp_y", e.model_zmp_y, got.model_zmp_y);
            compare("jerk_x", e.jerk_x, got.jerk_x);
            compare("jerk_y", e.jerk_y, got.jerk_y);
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    zmpc_in_t          in_data;
    logic              out_valid;
    logic              out_ready;
    zmpc_out_t         out_data;
    logic              cfg_we;
    logic [CFG_IW-1:0] cfg_index;
    logic [CFG_DW-1:0] cfg_data;

    com_scoreboard sb;
    bit            calm;
    int            out_hold;
    int            quiet_cycles;

    zmp_preview_com_controller u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // q16.16 value: mostly modest, sometimes an extreme
    function automatic int pick_q(int span);
        case ($urandom_range(0, 19))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return 0;
            3: return -1;
            4: return int'($urandom);
            default: return int'($urandom_range(0, 2*span)) - span;
        endcase
    endfunction

    // result side: random back-pressure and checking
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result(out_data);
            if (calm)
                out_ready <= 1'b1;
            else if (out_hold > 0)
            begin
                out_hold--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    out_hold = pick_gap();
            end
        end
    end

    // watchdog on cycles with no transaction
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // one input transaction, valid held until accepted
    task automatic send(input zmpc_in_t d);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= d;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(d);
    endtask

    task automatic send_op(input logic [1:0] op, input int idx, input int val,
                           input int rx, input int ry);
        zmpc_in_t d;
        d.opcode     = op;
        d.coef_index = 11'(idx);
        d.coef_value = val;
        d.ref_x      = rx;
        d.ref_y      = ry;
        send(d);
    endtask

    task automatic send_sample();
        send_op(OP_SAMPLE, $urandom_range(0, 2047), int'($urandom),
                pick_q(1 << 20), pick_q(1 << 20));
    endtask

    // drain every result, then let any ignored work finish
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (IDLE_WAIT) @(posedge clk);
    endtask

    task automatic write_regs(input int v_dt, input int v_hdt2, input int v_sdt3,
                              input int v_hog);
        int vals[4];
        vals = '{v_dt, v_hdt2, v_sdt3, v_hog};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IW'(i);
            cfg_data  <= CFG_DW'(vals[i]);
            @(posedge clk);
            sb.write_reg(CFG_IW'(i), CFG_DW'(vals[i]));
        end
        cfg_we <= 1'b0;
    endtask

    // stimulus
    initial
    begin
        int r;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        out_ready    = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        calm         = 1'b0;
        out_hold     = 0;
        quiet_cycles = 0;
        sb           = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every gain word gets a value before any result can read it
        for (int i = 0; i < GAIN_WORDS; i++)
            send_op(OP_LOAD, i, pick_q(1 << 11), int'($urandom), int'($urandom));

        // directed: ignored codes, out-of-range loads, restart on a part window
        send_op(OP_SPARE, 11'h7ff, -1, -1, -1);
        send_op(OP_LOAD, 2047, 32'sh8000_0000, 0, 0);
        send_op(OP_LOAD, GAIN_WORDS, 32'sh7fff_ffff, 0, 0);
        send_op(OP_RESTART, 0, 0, 0, 0);
        send_op(OP_SAMPLE, 0, 0, 32'sh7fff_ffff, 32'sh8000_0000);
        send_op(OP_SAMPLE, 0, 0, 32'sh8000_0000, 32'sh7fff_ffff);
        send_op(OP_SAMPLE, 0, 0, -1, 0);
        send_op(OP_RESTART, 0, 0, 0, 0);
        for (int i = 0; i < PREVIEW_LEN; i++)
            send_sample();
        // saturating gains on a full window, then back to modest ones
        send_op(OP_LOAD, 0, 32'sh7fff_ffff, 0, 0);
        send_op(OP_LOAD, 5, 32'sh8000_0000, 0, 0);
        send_op(OP_SAMPLE, 0, 0, 32'sh7fff_ffff, 32'sh7fff_ffff);
        send_op(OP_SAMPLE, 0, 0, 32'sh8000_0000, 32'sh8000_0000);
        send_op(OP_LOAD, 0, 1000, 0, 0);
        send_op(OP_LOAD, 5, -1000, 0, 0);
        send_op(OP_SAMPLE, 0, 0, 0, 0);

        // phases across register settings
        for (int ph = 0; ph < 5; ph++)
        begin
            wait_idle();
            case (ph)
                0: write_regs(655, 3, 0, 5679);
                1: write_regs(0, 0, 0, 0);
                2: write_regs(21'h1fffff, 21'h1fffff, 21'h1fffff, 21'h1fffff);
                3: write_regs($urandom_range(0, 65536), $urandom_range(0, 65536),
                              $urandom_range(0, 65536), $urandom_range(0, 1048576));
                default: write_regs(65536, 65536, 65536, 1048576);
            endcase
            calm = (ph == 1);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 85)
                    send_sample();
                else if (r < 93)
                    send_op(OP_LOAD, $urandom_range(0, GAIN_WORDS - 1), pick_q(1 << 11),
                            int'($urandom), int'($urandom));
                else if (r < 97)
                    send_op(OP_LOAD, $urandom_range(GAIN_WORDS, 2047), int'($urandom),
                            int'($urandom), int'($urandom));
                else
                    send_op(OP_SPARE, $urandom_range(0, 2047), int'($urandom),
                            int'($urandom), int'($urandom));
            end
            calm = 1'b0;
        end

        // drain and report
        wait_idle();
        if (sb.pending.size() != 0)
        begin
            $error("%0d predicted results never arrived", sb.pending.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
